// ===== src/swdt_pkg.sv =====
// shared types and constants for the stall watchdog delivery tracker
package swdt_pkg;

   localparam int WORD_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOUND_AT_BOOT = 2'd2;

   localparam logic [WORD_W-1:0] STALL_LIMIT_RST = 32'd60000;
   localparam logic [WORD_W-1:0] GRACE_RST = 32'd30000;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_wr_type;

   typedef struct packed {
      logic [WORD_W-1:0] now_ms;
      logic [WORD_W-1:0] heartbeat_ms;
      logic              update_running;
      logic [WORD_W-1:0] batches_ok;
      logic [WORD_W-1:0] ack_hi_seq;
      logic [WORD_W-1:0] dropped_max_seq;
      logic              record_present;
      logic [WORD_W-1:0] feed_head_seq;
      logic [WORD_W-1:0] feed_tail_seq;
   } req_beat_type;

   typedef struct packed {
      logic do_feed;
      logic refeed_needed;
      logic clear_record;
      logic pending_now;
      logic fed_now;
   } dlv_out_type;

   typedef struct packed {
      logic              stall_res;
      logic              armed_now;
      logic [WORD_W-1:0] age_ms;
      logic              halted;
      logic              start_taken;
   } wdg_out_type;

   typedef struct packed {
      logic              do_feed;
      logic              refeed_needed;
      logic              clear_record;
      logic              stall_res;
      logic              armed_now;
      logic [WORD_W-1:0] age_ms;
      logic              pending_now;
      logic              fed_now;
   } rsp_beat_type;

endpackage

// ===== src/swdt_req_if.sv =====
// check tick channel
interface swdt_req_if;
   import swdt_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] now_ms;
   logic [WORD_W-1:0] heartbeat_ms;
   logic              update_running;
   logic [WORD_W-1:0] batches_ok;
   logic [WORD_W-1:0] ack_hi_seq;
   logic [WORD_W-1:0] dropped_max_seq;
   logic              record_present;
   logic [WORD_W-1:0] feed_head_seq;
   logic [WORD_W-1:0] feed_tail_seq;

   modport source (
      output valid, now_ms, heartbeat_ms, update_running, batches_ok, ack_hi_seq,
             dropped_max_seq, record_present, feed_head_seq, feed_tail_seq,
      input  ready
   );

   modport sink (
      input  valid, now_ms, heartbeat_ms, update_running, batches_ok, ack_hi_seq,
             dropped_max_seq, record_present, feed_head_seq, feed_tail_seq,
      output ready
   );

endinterface

// ===== src/swdt_rsp_if.sv =====
// tick result channel
interface swdt_rsp_if;
   import swdt_pkg::*;

   logic              valid;
   logic              ready;
   logic              do_feed;
   logic              refeed_needed;
   logic              clear_record;
   logic              stall_res;
   logic              armed_now;
   logic [WORD_W-1:0] age_ms;
   logic              pending_now;
   logic              fed_now;

   modport source (
      output valid, do_feed, refeed_needed, clear_record, stall_res, armed_now, age_ms,
             pending_now, fed_now,
      input  ready
   );

   modport sink (
      input  valid, do_feed, refeed_needed, clear_record, stall_res, armed_now, age_ms,
             pending_now, fed_now,
      output ready
   );

endinterface

// ===== src/swdt_delivery.sv =====
// delivery tracker for the stored crash record
module swdt_delivery (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   halted,
   input  logic                   start_taken,
   input  swdt_pkg::csr_wr_type   csr,
   input  swdt_pkg::req_beat_type beat,
   output swdt_pkg::dlv_out_type  result
);
   import swdt_pkg::*;

   logic              pending_ff, pending_in;
   logic              fed_ff, fed_in;
   logic [WORD_W-1:0] first_seq_ff, first_seq_in;
   logic [WORD_W-1:0] last_seq_ff, last_seq_in;
   logic [WORD_W-1:0] batches_at_feed_ff, batches_at_feed_in;
   logic              do_feed, refeed, clear;

   always_comb begin
      pending_in = pending_ff;
      fed_in = fed_ff;
      first_seq_in = first_seq_ff;
      last_seq_in = last_seq_ff;
      batches_at_feed_in = batches_at_feed_ff;
      do_feed = 1'b0;
      refeed = 1'b0;
      clear = 1'b0;
      if (!halted && pending_ff) begin
         // a fed line got dropped: forget the feed
         if (fed_ff && first_seq_ff != '0 && beat.dropped_max_seq >= first_seq_ff) begin
            fed_in = 1'b0;
            first_seq_in = '0;
            last_seq_in = '0;
            refeed = 1'b1;
         end
         if (!fed_in) begin
            if (beat.batches_ok > batches_at_feed_ff) begin
               if (!beat.record_present) begin
                  pending_in = 1'b0;
               end else begin
                  first_seq_in = beat.feed_head_seq;
                  last_seq_in = (beat.feed_head_seq != '0) ? beat.feed_tail_seq : '0;
                  if (beat.feed_head_seq != '0) begin
                     fed_in = 1'b1;
                     batches_at_feed_in = beat.batches_ok;
                     do_feed = 1'b1;
                  end
               end
            end
         end else if (last_seq_in != '0 && beat.ack_hi_seq >= last_seq_in) begin
            pending_in = 1'b0;
            clear = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         fed_ff <= 1'b0;
         first_seq_ff <= '0;
         last_seq_ff <= '0;
         batches_at_feed_ff <= '0;
      end else if (step) begin
         pending_ff <= pending_in;
         fed_ff <= fed_in;
         first_seq_ff <= first_seq_in;
         last_seq_ff <= last_seq_in;
         batches_at_feed_ff <= batches_at_feed_in;
      end else if (csr.we && csr.index == CSR_FOUND_AT_BOOT && !start_taken) begin
         // boot record flag seeds pending until the first tick
         pending_ff <= csr.wdata[0];
      end
   end

   assign result.do_feed = do_feed;
   assign result.refeed_needed = refeed;
   assign result.clear_record = clear;
   assign result.pending_now = pending_in;
   assign result.fed_now = fed_in;

`ifndef SYNTHESIS
   a_pending_no_return: assert property (@(posedge clock) disable iff (reset)
      (step && !pending_ff) |=> !pending_ff)
      else $error("pending came back after a tick");
   a_fed_has_seq: assert property (@(posedge clock) disable iff (reset)
      fed_ff |-> first_seq_ff != '0)
      else $error("fed record without first sequence");
   a_halt_freezes: assert property (@(posedge clock) disable iff (reset)
      (step && halted) |=> $stable(fed_ff) && $stable(first_seq_ff) && $stable(last_seq_ff))
      else $error("delivery state moved while halted");
`endif

endmodule

// ===== src/swdt_watchdog.sv =====
// heartbeat watchdog with grace time, arming and update hold
module swdt_watchdog (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  swdt_pkg::csr_wr_type   csr,
   input  swdt_pkg::req_beat_type beat,
   output swdt_pkg::wdg_out_type  result
);
   import swdt_pkg::*;

   logic [WORD_W-1:0] stall_limit_ff;
   logic [WORD_W-1:0] grace_ff;
   logic              armed_ff, armed_in;
   logic [WORD_W-1:0] start_time_ff, start_time_in;
   logic              start_taken_ff;
   logic [WORD_W-1:0] last_age_ff, last_age_in;
   logic              halted_ff, halted_in;
   logic [WORD_W-1:0] start_eff;
   logic [WORD_W-1:0] since_start;
   logic [WORD_W-1:0] hb_age;
   logic              stall;

   // first tick takes its own time as the start
   assign start_eff = start_taken_ff ? start_time_ff : beat.now_ms;
   assign since_start = beat.now_ms - start_eff;
   assign hb_age = beat.now_ms - beat.heartbeat_ms;

   always_comb begin
      armed_in = armed_ff;
      start_time_in = start_time_ff;
      last_age_in = last_age_ff;
      halted_in = halted_ff;
      stall = halted_ff;
      if (!halted_ff) begin
         start_time_in = start_eff;
         if (beat.update_running) begin
            start_time_in = beat.now_ms;
            armed_in = 1'b0;
         end else begin
            if (!armed_ff && since_start >= grace_ff && beat.heartbeat_ms != '0) begin
               armed_in = 1'b1;
            end
            if (armed_in) begin
               last_age_in = hb_age;
               if (hb_age >= stall_limit_ff) begin
                  stall = 1'b1;
                  halted_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_limit_ff <= STALL_LIMIT_RST;
         grace_ff <= GRACE_RST;
      end else if (csr.we) begin
         if (csr.index == CSR_STALL_LIMIT) begin
            stall_limit_ff <= csr.wdata[WORD_W-1:0];
         end
         if (csr.index == CSR_GRACE) begin
            grace_ff <= csr.wdata[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         start_time_ff <= '0;
         start_taken_ff <= 1'b0;
         last_age_ff <= '0;
         halted_ff <= 1'b0;
      end else if (step) begin
         armed_ff <= armed_in;
         start_time_ff <= start_time_in;
         start_taken_ff <= start_taken_ff | ~halted_ff;
         last_age_ff <= last_age_in;
         halted_ff <= halted_in;
      end
   end

   assign result.stall_res = stall;
   assign result.armed_now = armed_in;
   assign result.age_ms = last_age_in;
   assign result.halted = halted_ff;
   assign result.start_taken = start_taken_ff;

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");
   a_halt_when_armed: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> armed_ff && start_taken_ff)
      else $error("halted without being armed");
   a_update_disarms: assert property (@(posedge clock) disable iff (reset)
      (step && !halted_ff && beat.update_running) |=> !armed_ff)
      else $error("armed across a running update");
`endif

endmodule

// ===== src/stall_watchdog_delivery_tracker.sv =====
// top level: tick input register, tracker and watchdog, result register
// One check tick per beat; a beat is registered on entry, its whole update (delivery tracking
// plus heartbeat watchdog) is worked out combinationally from that register and the held
// state, and the result lands in an output register. rsp valid comes from that register,
// loaded from the input register once it is empty or being drained, and a new tick is
// taken every cycle as long as the result side keeps up;
// the input register and the result register let one tick wait on each side. Once a stall
// is declared the block halts: every later tick answers stall_res high and the held state,
// until reset. The csr port writes stall_limit_ms, grace_ms and found_at_boot; found_at_boot
// also seeds the pending flag while no tick has been seen yet.
module stall_watchdog_delivery_tracker (
   input  logic                                clock,
   input  logic                                reset,
   swdt_req_if.sink                            req_chan,
   swdt_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [swdt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swdt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import swdt_pkg::*;

   logic         in_valid_ff;
   req_beat_type beat_ff;
   logic         rsp_valid_ff;
   rsp_beat_type rsp_ff;
   logic         advance;
   csr_wr_type   csr;
   dlv_out_type  dlv;
   wdg_out_type  wdg;

   assign csr.we = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // tick moves on when the result register is empty or being drained
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         beat_ff.now_ms <= req_chan.now_ms;
         beat_ff.heartbeat_ms <= req_chan.heartbeat_ms;
         beat_ff.update_running <= req_chan.update_running;
         beat_ff.batches_ok <= req_chan.batches_ok;
         beat_ff.ack_hi_seq <= req_chan.ack_hi_seq;
         beat_ff.dropped_max_seq <= req_chan.dropped_max_seq;
         beat_ff.record_present <= req_chan.record_present;
         beat_ff.feed_head_seq <= req_chan.feed_head_seq;
         beat_ff.feed_tail_seq <= req_chan.feed_tail_seq;
      end
   end

   swdt_delivery u_delivery (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .halted      (wdg.halted),
      .start_taken (wdg.start_taken),
      .csr         (csr),
      .beat        (beat_ff),
      .result      (dlv)
   );

   swdt_watchdog u_watchdog (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .csr    (csr),
      .beat   (beat_ff),
      .result (wdg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.do_feed <= dlv.do_feed;
         rsp_ff.refeed_needed <= dlv.refeed_needed;
         rsp_ff.clear_record <= dlv.clear_record;
         rsp_ff.stall_res <= wdg.stall_res;
         rsp_ff.armed_now <= wdg.armed_now;
         rsp_ff.age_ms <= wdg.age_ms;
         rsp_ff.pending_now <= dlv.pending_now;
         rsp_ff.fed_now <= dlv.fed_now;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.do_feed = rsp_ff.do_feed;
   assign rsp_chan.refeed_needed = rsp_ff.refeed_needed;
   assign rsp_chan.clear_record = rsp_ff.clear_record;
   assign rsp_chan.stall_res = rsp_ff.stall_res;
   assign rsp_chan.armed_now = rsp_ff.armed_now;
   assign rsp_chan.age_ms = rsp_ff.age_ms;
   assign rsp_chan.pending_now = rsp_ff.pending_now;
   assign rsp_chan.fed_now = rsp_ff.fed_now;

`ifndef SYNTHESIS
   a_stall_armed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.stall_res) |-> rsp_ff.armed_now)
      else $error("stall reported while not armed");
   a_feed_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.do_feed) |-> rsp_ff.fed_now && rsp_ff.pending_now)
      else $error("feed beat without fed pending record");
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.clear_record) |-> !rsp_ff.pending_now && !rsp_ff.do_feed)
      else $error("clear beat left record pending");
   a_no_lost_tick: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(beat_ff))
      else $error("waiting tick dropped or overwritten");
`endif

endmodule
